// ----- hw/rtl/smf_pkg.sv -----
// ----------------------------------------------------------------------------
// smf_pkg: shared definitions for the sliding median / mean filter
// Default sizes, filter mode codes and the stage control struct.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smf_pkg;

  // Default window length and sample value width
  localparam int DEF_WINDOW      = 5;
  localparam int DEF_VALUE_WIDTH = 32;

  // Timestamp width is fixed
  localparam int TIME_WIDTH = 32;

  // Reciprocal bits folded into the product by one divider cell
  localparam int DIV_DIGIT = 16;

  // Filter mode codes
  localparam logic MODE_MEDIAN = 1'b0;
  localparam logic MODE_MEAN   = 1'b1;

  // Control that travels with a beat down the pipeline
  typedef struct packed {
    logic vld;
    logic mode;
  } smf_ctl_t;

endpackage

// ----- hw/rtl/smf_tap_cell.sv -----
// ----------------------------------------------------------------------------
// smf_tap_cell: one tap of the sample window
// Holds one sample and hands it to its older neighbor on each accepted beat;
// ranks its incoming value against the incoming window to flag the median.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smf_tap_cell #(
  parameter int WINDOW      = smf_pkg::DEF_WINDOW,
  parameter int VALUE_WIDTH = smf_pkg::DEF_VALUE_WIDTH,
  parameter int IDX         = 0
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  shift,
  input  logic [VALUE_WIDTH-1:0]                d_value,
  input  logic [smf_pkg::TIME_WIDTH-1:0]        d_time,
  input  logic                                  d_live,
  input  logic [WINDOW-1:0][VALUE_WIDTH-1:0]    window,
  output logic [VALUE_WIDTH-1:0]                value,
  output logic [smf_pkg::TIME_WIDTH-1:0]        stamp,
  output logic                                  live,
  output logic                                  pick
);
  import smf_pkg::*;

  localparam int CNT_WIDTH = $clog2(WINDOW);
  localparam int CENTER    = WINDOW / 2;

  logic [CNT_WIDTH-1:0] rank;

  // Count entries sorting ahead of this one; equal values break by position
  always_comb begin
    rank = '0;
    for (int j = 0; j < WINDOW; j++) begin
      if (j != IDX) begin
        if (($signed(window[j]) < $signed(window[IDX])) ||
            ((window[j] == window[IDX]) && (j < IDX))) begin
          rank = rank + CNT_WIDTH'(1);
        end
      end
    end
  end

  assign pick = (rank == CNT_WIDTH'(CENTER));

  // Advance the sample on an accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      live <= 1'b0;
    end else if (shift) begin
      live <= d_live;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      value <= d_value;
      stamp <= d_time;
    end
  end

endmodule

// ----- hw/rtl/smf_div_cell.sv -----
// ----------------------------------------------------------------------------
// smf_div_cell: one stage of the divide-by-window pipeline
// Multiplies the biased window sum by one slice of the window reciprocal,
// adds it into the running product and carries the median and timestamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smf_div_cell #(
  parameter int VALUE_WIDTH = smf_pkg::DEF_VALUE_WIDTH,
  parameter int ACC_WIDTH   = smf_pkg::DEF_VALUE_WIDTH + 8,
  parameter int PROD_WIDTH  = smf_pkg::DEF_VALUE_WIDTH + 8 + 3 * smf_pkg::DIV_DIGIT,
  parameter int OFFSET      = 0,
  parameter logic [smf_pkg::DIV_DIGIT-1:0] FACTOR = '0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  smf_pkg::smf_ctl_t              ctl_in,
  input  logic [ACC_WIDTH-1:0]           work_in,
  input  logic [PROD_WIDTH-1:0]          prod_in,
  input  logic [VALUE_WIDTH-1:0]         med_in,
  input  logic [smf_pkg::TIME_WIDTH-1:0] time_in,
  output smf_pkg::smf_ctl_t              ctl,
  output logic [ACC_WIDTH-1:0]           work,
  output logic [PROD_WIDTH-1:0]          prod,
  output logic [VALUE_WIDTH-1:0]         med,
  output logic [smf_pkg::TIME_WIDTH-1:0] stamp
);
  import smf_pkg::*;

  localparam int MUL_WIDTH = ACC_WIDTH + DIV_DIGIT;

  logic [MUL_WIDTH-1:0]  part;
  logic [PROD_WIDTH-1:0] prod_next;

  // Multiply by this cell's reciprocal slice and accumulate at its offset
  assign part      = MUL_WIDTH'(work_in) * MUL_WIDTH'(FACTOR);
  assign prod_next = prod_in + (PROD_WIDTH'(part) << OFFSET);

  // Hold the beat unless the next stage frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.vld <= 1'b0;
    end else if (load) begin
      ctl.vld <= ctl_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ctl.mode <= ctl_in.mode;
      work     <= work_in;
      prod     <= prod_next;
      med      <= med_in;
      stamp    <= time_in;
    end
  end

endmodule

// ----- hw/rtl/sliding_median_or_mean_filter_core.sv -----
// ----------------------------------------------------------------------------
// sliding_median_or_mean_filter_core: sliding median / mean over a window
// Chain of tap cells holds the window; a chain of divider cells floors the
// running window sum by the window length while the median rides along.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle while sample_stall is low; a sample whose
// window is full gives a beat, which passes the front stage and then STAGES
//   divider cells, STAGES being ceil((VALUE_WIDTH + 9) / 16), to the result.
// The reciprocal multiply folds sixteen bits per cell and sets STAGES.
// Reset empties the window, sets median mode and drops every beat in flight.
`timescale 1ns / 1ps

module sliding_median_or_mean_filter_core #(
  parameter int WINDOW      = smf_pkg::DEF_WINDOW,
  parameter int VALUE_WIDTH = smf_pkg::DEF_VALUE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_wr_data,
  input  logic                           sample_valid,
  output logic                           sample_stall,
  input  logic signed [VALUE_WIDTH-1:0]  sample_value,
  input  logic [smf_pkg::TIME_WIDTH-1:0] sample_time,
  input  logic                           new_series,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic signed [VALUE_WIDTH-1:0]  filtered_value,
  output logic [smf_pkg::TIME_WIDTH-1:0] center_time
);
  import smf_pkg::*;

  localparam int SUM_WIDTH   = VALUE_WIDTH + 4;
  localparam int ACC_WIDTH   = SUM_WIDTH + 4;
  localparam int LOG_WIN     = $clog2(WINDOW);
  localparam int RSHIFT      = ACC_WIDTH + LOG_WIN;
  localparam int RECIP_WIDTH = ACC_WIDTH + 1;
  localparam int STAGES      = (RECIP_WIDTH + DIV_DIGIT - 1) / DIV_DIGIT;
  localparam int RECIP_PAD   = STAGES * DIV_DIGIT;
  localparam int PROD_WIDTH  = ACC_WIDTH + RECIP_PAD;
  localparam int CENTER      = WINDOW / 2;
  // Offset that keeps the biased sum positive; a multiple of the window length
  // times a power of two at or above VALUE_WIDTH, so low quotient bits are exact
  localparam logic [ACC_WIDTH-1:0] BIAS = ACC_WIDTH'(WINDOW) << (SUM_WIDTH - 1);
  localparam logic [WINDOW-1:0]    LIVE_TOP = {1'b1, {(WINDOW-1){1'b0}}};
  // Rounded-up reciprocal; exact floor for every biased sum below 2^ACC_WIDTH
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << RSHIFT) + 64'(WINDOW - 1)) / 64'(WINDOW);
  localparam logic [RECIP_PAD-1:0] RECIP = RECIP_PAD'(RECIP_FULL);

  logic filter_mode;
  logic accept;
  logic full_next;

  logic [WINDOW-1:0][VALUE_WIDTH-1:0] cur_value, nxt_value;
  logic [WINDOW-1:0][TIME_WIDTH-1:0]  cur_time, nxt_time;
  logic [WINDOW-1:0]                  cur_live, nxt_live, pick;

  logic [VALUE_WIDTH-1:0] med_value;
  logic [ACC_WIDTH-1:0]   acc, acc_next, new_ext, old_ext;

  smf_ctl_t               front_ctl;
  logic [ACC_WIDTH-1:0]   front_work;
  logic [VALUE_WIDTH-1:0] front_med;
  logic [TIME_WIDTH-1:0]  front_time;

  smf_ctl_t               ctl   [0:STAGES];
  logic [ACC_WIDTH-1:0]   work  [0:STAGES];
  logic [PROD_WIDTH-1:0]  prod  [0:STAGES];
  logic [VALUE_WIDTH-1:0] med   [0:STAGES];
  logic [TIME_WIDTH-1:0]  stamp [0:STAGES];
  logic [STAGES:0]        adv;

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode <= MODE_MEDIAN;
    end else if (cfg_wr_en) begin
      filter_mode <= cfg_wr_data;
    end
  end

  // Stage advance: a stage loads when empty or when its successor moves
  assign adv[STAGES] = ~result_stall;
  for (genvar k = 0; k < STAGES; k++) begin : g_adv
    assign adv[k] = ~ctl[k].vld | adv[k+1];
  end

  assign sample_stall = ~adv[0];
  assign accept       = sample_valid & adv[0];

  // Window chain: each tap takes its younger neighbor, the youngest the input
  for (genvar i = 0; i < WINDOW; i++) begin : g_tap
    if (i == WINDOW - 1) begin : g_top
      assign nxt_value[i] = sample_value;
      assign nxt_time[i]  = sample_time;
      assign nxt_live[i]  = 1'b1;
    end else begin : g_mid
      assign nxt_value[i] = cur_value[i+1];
      assign nxt_time[i]  = cur_time[i+1];
      assign nxt_live[i]  = cur_live[i+1] & ~new_series;
    end

    smf_tap_cell #(
      .WINDOW      (WINDOW),
      .VALUE_WIDTH (VALUE_WIDTH),
      .IDX         (i)
    ) u_tap (
      .clk     (clk),
      .rst     (rst),
      .shift   (accept),
      .d_value (nxt_value[i]),
      .d_time  (nxt_time[i]),
      .d_live  (nxt_live[i]),
      .window  (nxt_value),
      .value   (cur_value[i]),
      .stamp   (cur_time[i]),
      .live    (cur_live[i]),
      .pick    (pick[i])
    );
  end

  assign full_next = &nxt_live;

  // Select the tap whose rank is the middle one
  always_comb begin
    med_value = '0;
    for (int i = 0; i < WINDOW; i++) begin
      med_value = med_value | ({VALUE_WIDTH{pick[i]}} & nxt_value[i]);
    end
  end

  // Running biased sum: add the entering sample, drop the leaving live one
  assign new_ext  = {{(ACC_WIDTH-VALUE_WIDTH){sample_value[VALUE_WIDTH-1]}}, sample_value};
  assign old_ext  = cur_live[0] ?
                    {{(ACC_WIDTH-VALUE_WIDTH){cur_value[0][VALUE_WIDTH-1]}}, cur_value[0]} :
                    '0;
  assign acc_next = new_series ? (BIAS + new_ext) : (acc + new_ext - old_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= BIAS;
    end else if (accept) begin
      acc <= acc_next;
    end
  end

  // Front stage: capture the beat for the divider chain
  always_ff @(posedge clk) begin
    if (rst) begin
      front_ctl.vld <= 1'b0;
    end else if (adv[0]) begin
      front_ctl.vld <= accept & full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_ctl.mode <= filter_mode;
      front_work     <= acc_next;
      front_med      <= med_value;
      front_time     <= nxt_time[CENTER];
    end
  end

  assign ctl[0]   = front_ctl;
  assign work[0]  = front_work;
  assign prod[0]  = '0;
  assign med[0]   = front_med;
  assign stamp[0] = front_time;

  // Divider chain: one reciprocal slice per cell
  for (genvar k = 1; k <= STAGES; k++) begin : g_div
    smf_div_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .ACC_WIDTH   (ACC_WIDTH),
      .PROD_WIDTH  (PROD_WIDTH),
      .OFFSET      ((k - 1) * DIV_DIGIT),
      .FACTOR      (RECIP[(k-1)*DIV_DIGIT +: DIV_DIGIT])
    ) u_div (
      .clk     (clk),
      .rst     (rst),
      .load    (adv[k]),
      .ctl_in  (ctl[k-1]),
      .work_in (work[k-1]),
      .prod_in (prod[k-1]),
      .med_in  (med[k-1]),
      .time_in (stamp[k-1]),
      .ctl     (ctl[k]),
      .work    (work[k]),
      .prod    (prod[k]),
      .med     (med[k]),
      .stamp   (stamp[k])
    );
  end

  // Result beat from the last cell
  assign result_valid   = ctl[STAGES].vld;
  assign filtered_value = (ctl[STAGES].mode == MODE_MEAN) ?
                          prod[STAGES][RSHIFT +: VALUE_WIDTH] : med[STAGES];
  assign center_time    = stamp[STAGES];

`ifndef ASSERT_OFF
  a_no_beat_unfilled: assert property (@(posedge clk) disable iff (rst)
    accept && !full_next |=> !front_ctl.vld)
    else $error("front stage took a beat from a window that was not full");

  a_series_restart: assert property (@(posedge clk) disable iff (rst)
    accept && new_series |=> cur_live == LIVE_TOP)
    else $error("new series left stale taps live");

  a_flow_when_drained: assert property (@(posedge clk) disable iff (rst)
    adv[STAGES] |-> !sample_stall)
    else $error("input stalled while the output side moves");

  a_single_median: assert property (@(posedge clk) disable iff (rst)
    accept && full_next |-> $onehot(pick))
    else $error("median select is not one tap");

  a_front_hold: assert property (@(posedge clk) disable iff (rst)
    front_ctl.vld && !adv[1] |=> front_ctl.vld && $stable(front_work))
    else $error("front stage lost a blocked beat");
`endif

endmodule
